[sv/tcst_pkg.sv]
// Package for the telephone call state table: table sizing, codes, entry and item types.
// Used by every RTL file of the block; it depends on nothing.
package tcst_pkg;

    localparam int MAX_LINES = 64;
    localparam int UNIT_W    = 6;
    localparam int DIAL_W    = 8;
    localparam int TBL_DEPTH = (MAX_LINES < (1 << UNIT_W)) ? MAX_LINES : (1 << UNIT_W);
    localparam int IDX_W     = $clog2(TBL_DEPTH);

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [2:0] {
        CMD_REGISTER   = 3'd0,
        CMD_UNREGISTER = 3'd1,
        CMD_PICKUP     = 3'd2,
        CMD_HANGUP     = 3'd3,
        CMD_DIAL       = 3'd4,
        CMD_CHAT       = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        LS_ON_HOOK   = 3'd0,
        LS_RINGING   = 3'd1,
        LS_DIAL_TONE = 3'd2,
        LS_RING_BACK = 3'd3,
        LS_BUSY      = 3'd4,
        LS_CONNECTED = 3'd5,
        LS_ERROR     = 3'd6
    } t_line_state;

    typedef enum logic [1:0] {
        KIND_NOTICE  = 2'd0,
        KIND_FORWARD = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEER,
        S_EXEC,
        S_WRITE_U,
        S_OUT_FIRST,
        S_OUT_LAST
    } t_state;

    typedef struct packed {
        logic        registered;
        t_line_state ls;
        logic        peer_valid;
        t_idx        peer_idx;
    } t_entry;

    typedef struct packed {
        logic   rd_en;
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_entry wr_data;
    } t_tbl_req;

    typedef struct packed {
        logic [UNIT_W-1:0] target;
        t_kind             kind;
        t_line_state       ls;
        logic [UNIT_W-1:0] shown;
    } t_item;

    function automatic logic in_table(logic [DIAL_W-1:0] v);
        return (32'(v) < TBL_DEPTH);
    endfunction

    function automatic t_item notice_of(t_idx x, t_entry e);
        t_item it;
        it.target = UNIT_W'(x);
        it.kind   = KIND_NOTICE;
        it.ls     = e.ls;
        if (e.ls == LS_ON_HOOK) begin
            it.shown = UNIT_W'(x);
        end else if (e.ls == LS_CONNECTED && e.peer_valid) begin
            it.shown = UNIT_W'(e.peer_idx);
        end else begin
            it.shown = '0;
        end
        return it;
    endfunction

endpackage

[sv/tcst_if.sv]
// Handshake interfaces of the call state table: the command channel and the result channel.
// Depends on tcst_pkg for the field widths.
interface tcst_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    cmd;
    logic [tcst_pkg::UNIT_W-1:0]   unit;
    logic [tcst_pkg::DIAL_W-1:0]   dialed;

    modport source (output valid, output cmd, output unit, output dialed, input ready);
    modport sink   (input valid, input cmd, input unit, input dialed, output ready);
endinterface

interface tcst_res_if;
    logic                          valid;
    logic                          ready;
    logic [tcst_pkg::UNIT_W-1:0]   target;
    logic [1:0]                    kind;
    logic [2:0]                    line_state_out;
    logic [tcst_pkg::UNIT_W-1:0]   shown_number;
    logic                          failed;
    logic                          last;

    modport source (output valid, output target, output kind, output line_state_out,
                    output shown_number, output failed, output last, input ready);
    modport sink   (input valid, input target, input kind, input line_state_out,
                    input shown_number, input failed, input last, output ready);
endinterface

[sv/tcst_table.sv]
// Extension table: flag vectors cleared at reset plus a memory with separate read and write ports.
// Depends on tcst_pkg; one read and one write per cycle, read data registered.
module tcst_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcst_pkg::t_tbl_req  i_req,
    output tcst_pkg::t_entry    o_rd
);

    logic [tcst_pkg::TBL_DEPTH-1:0] r_registered;
    logic [tcst_pkg::TBL_DEPTH-1:0] r_peer_valid;
    logic [tcst_pkg::TBL_DEPTH-1:0] r_ls_valid;
    logic [2+tcst_pkg::IDX_W:0]     r_mem [tcst_pkg::TBL_DEPTH];
    logic [2+tcst_pkg::IDX_W:0]     r_rd_word;
    logic                           r_rd_reg;
    logic                           r_rd_pv;
    logic                           r_rd_lsv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_registered <= '0;
            r_peer_valid <= '0;
            r_ls_valid   <= '0;
        end else if (i_req.wr_en) begin
            r_registered[i_req.wr_addr] <= i_req.wr_data.registered;
            r_peer_valid[i_req.wr_addr] <= i_req.wr_data.peer_valid;
            r_ls_valid[i_req.wr_addr]   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= {i_req.wr_data.ls, i_req.wr_data.peer_idx};
        end
        if (i_req.rd_en) begin
            r_rd_word <= r_mem[i_req.rd_addr];
            r_rd_reg  <= r_registered[i_req.rd_addr];
            r_rd_pv   <= r_peer_valid[i_req.rd_addr];
            r_rd_lsv  <= r_ls_valid[i_req.rd_addr];
        end
    end

    always_comb begin
        o_rd.registered = r_rd_reg;
        o_rd.peer_valid = r_rd_pv;
        o_rd.peer_idx   = r_rd_word[tcst_pkg::IDX_W-1:0];
        o_rd.ls         = r_rd_lsv ? tcst_pkg::t_line_state'(r_rd_word[2+tcst_pkg::IDX_W:tcst_pkg::IDX_W])
                                   : tcst_pkg::LS_ON_HOOK;
    end

endmodule

[sv/tcst_ctrl.sv]
// Command sequencer: reads caller and peer entries, applies the call rules, writes both back
// and delivers the result transactions. Depends on tcst_pkg and the channel interfaces.
module tcst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tcst_cmd_if.sink            i_cmd,
    tcst_res_if.source          o_res,
    output tcst_pkg::t_tbl_req  o_req,
    input  tcst_pkg::t_entry    i_rd
);

    tcst_pkg::t_state               r_state, n_state;
    logic [2:0]                     r_cmd;
    logic [tcst_pkg::UNIT_W-1:0]    r_unit;
    logic [tcst_pkg::DIAL_W-1:0]    r_dialed;
    tcst_pkg::t_idx                 r_paddr;
    tcst_pkg::t_entry               r_eu;
    tcst_pkg::t_entry               r_nu;
    logic                           r_wr_u;
    tcst_pkg::t_item                r_first;
    tcst_pkg::t_item                r_last;
    logic                           r_two;
    logic                           r_fail;

    tcst_pkg::t_idx                 c_uidx;
    tcst_pkg::t_entry               c_nu, c_np;
    logic                           c_wr_u, c_wr_p, c_two, c_fail;
    tcst_pkg::t_item                c_first, c_last, c_status;
    tcst_pkg::t_item                c_item;

    assign c_uidx = r_unit[tcst_pkg::IDX_W-1:0];

    always_comb begin
        c_nu     = r_eu;
        c_np     = i_rd;
        c_wr_u   = 1'b0;
        c_wr_p   = 1'b0;
        c_two    = 1'b0;
        c_fail   = 1'b0;
        c_status = '{target: r_unit, kind: tcst_pkg::KIND_STATUS,
                     ls: tcst_pkg::LS_ON_HOOK, shown: '0};
        c_first  = c_status;
        c_last   = c_status;
        if (!tcst_pkg::in_table(tcst_pkg::DIAL_W'(r_unit)) ||
            (r_cmd != tcst_pkg::CMD_REGISTER && !r_eu.registered)) begin
            c_fail = 1'b1;
        end else begin
            unique case (r_cmd)
                tcst_pkg::CMD_REGISTER: begin
                    if (r_eu.registered) begin
                        c_fail = 1'b1;
                    end else begin
                        c_nu.registered = 1'b1;
                        c_nu.ls         = tcst_pkg::LS_ON_HOOK;
                        c_nu.peer_valid = 1'b0;
                        c_wr_u          = 1'b1;
                        c_last          = tcst_pkg::notice_of(c_uidx, c_nu);
                    end
                end
                tcst_pkg::CMD_UNREGISTER: begin
                    if (r_eu.peer_valid) begin
                        if (i_rd.ls == tcst_pkg::LS_RING_BACK || i_rd.ls == tcst_pkg::LS_CONNECTED) begin
                            c_np.ls = tcst_pkg::LS_DIAL_TONE;
                        end else if (i_rd.ls == tcst_pkg::LS_RINGING) begin
                            c_np.ls = tcst_pkg::LS_ON_HOOK;
                        end
                        c_np.peer_valid = 1'b0;
                        c_wr_p          = 1'b1;
                        c_last          = tcst_pkg::notice_of(r_paddr, c_np);
                    end
                    c_nu.registered = 1'b0;
                    c_nu.ls         = tcst_pkg::LS_ON_HOOK;
                    c_nu.peer_valid = 1'b0;
                    c_wr_u          = 1'b1;
                end
                tcst_pkg::CMD_PICKUP: begin
                    if (r_eu.ls == tcst_pkg::LS_ON_HOOK) begin
                        c_nu.ls = tcst_pkg::LS_DIAL_TONE;
                    end else if (r_eu.ls == tcst_pkg::LS_RINGING && r_eu.peer_valid) begin
                        c_nu.ls = tcst_pkg::LS_CONNECTED;
                        c_np.ls = tcst_pkg::LS_CONNECTED;
                        c_wr_p  = 1'b1;
                        c_two   = 1'b1;
                        c_first = tcst_pkg::notice_of(r_paddr, c_np);
                    end
                    c_wr_u = 1'b1;
                    c_last = tcst_pkg::notice_of(c_uidx, c_nu);
                end
                tcst_pkg::CMD_HANGUP: begin
                    if ((r_eu.ls == tcst_pkg::LS_CONNECTED || r_eu.ls == tcst_pkg::LS_RING_BACK ||
                         r_eu.ls == tcst_pkg::LS_RINGING) && r_eu.peer_valid) begin
                        c_np.ls = (r_eu.ls == tcst_pkg::LS_RING_BACK) ? tcst_pkg::LS_ON_HOOK
                                                                       : tcst_pkg::LS_DIAL_TONE;
                        c_np.peer_valid = 1'b0;
                        c_wr_p          = 1'b1;
                        c_two           = 1'b1;
                        c_first         = tcst_pkg::notice_of(r_paddr, c_np);
                    end
                    c_nu.ls         = tcst_pkg::LS_ON_HOOK;
                    c_nu.peer_valid = 1'b0;
                    c_wr_u          = 1'b1;
                    c_last          = tcst_pkg::notice_of(c_uidx, c_nu);
                end
                tcst_pkg::CMD_DIAL: begin
                    if (r_eu.ls == tcst_pkg::LS_DIAL_TONE) begin
                        if (!tcst_pkg::in_table(r_dialed) || !i_rd.registered) begin
                            c_nu.ls = tcst_pkg::LS_ERROR;
                        end else if (i_rd.ls == tcst_pkg::LS_ON_HOOK) begin
                            c_nu.ls         = tcst_pkg::LS_RING_BACK;
                            c_nu.peer_valid = 1'b1;
                            c_nu.peer_idx   = r_paddr;
                            c_np.ls         = tcst_pkg::LS_RINGING;
                            c_np.peer_valid = 1'b1;
                            c_np.peer_idx   = c_uidx;
                            c_wr_p          = 1'b1;
                            c_two           = 1'b1;
                            c_first         = tcst_pkg::notice_of(r_paddr, c_np);
                        end else begin
                            c_nu.ls = tcst_pkg::LS_BUSY;
                        end
                    end
                    c_wr_u = 1'b1;
                    c_last = tcst_pkg::notice_of(c_uidx, c_nu);
                end
                tcst_pkg::CMD_CHAT: begin
                    if (r_eu.ls == tcst_pkg::LS_CONNECTED && r_eu.peer_valid) begin
                        c_two   = 1'b1;
                        c_first = '{target: tcst_pkg::UNIT_W'(r_eu.peer_idx),
                                    kind: tcst_pkg::KIND_FORWARD,
                                    ls: tcst_pkg::LS_ON_HOOK, shown: '0};
                    end else begin
                        c_fail = 1'b1;
                    end
                    c_last = tcst_pkg::notice_of(c_uidx, c_nu);
                end
                default: begin
                    c_fail = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcst_pkg::S_IDLE:      if (i_cmd.valid) n_state = tcst_pkg::S_PEER;
            tcst_pkg::S_PEER:      n_state = tcst_pkg::S_EXEC;
            tcst_pkg::S_EXEC:      n_state = tcst_pkg::S_WRITE_U;
            tcst_pkg::S_WRITE_U:   n_state = r_two ? tcst_pkg::S_OUT_FIRST : tcst_pkg::S_OUT_LAST;
            tcst_pkg::S_OUT_FIRST: if (o_res.ready) n_state = tcst_pkg::S_OUT_LAST;
            tcst_pkg::S_OUT_LAST:  if (o_res.ready) n_state = tcst_pkg::S_IDLE;
            default:               n_state = tcst_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_cmd.ready   = 1'b0;
        o_res.valid   = 1'b0;
        o_res.last    = 1'b0;
        c_item        = r_last;
        o_req         = '0;
        o_req.wr_data = c_np;
        unique case (r_state)
            tcst_pkg::S_IDLE: begin
                i_cmd.ready   = 1'b1;
                o_req.rd_en   = i_cmd.valid;
                o_req.rd_addr = i_cmd.unit[tcst_pkg::IDX_W-1:0];
            end
            tcst_pkg::S_PEER: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = (r_cmd == tcst_pkg::CMD_DIAL) ? r_dialed[tcst_pkg::IDX_W-1:0]
                                                              : i_rd.peer_idx;
            end
            tcst_pkg::S_EXEC: begin
                o_req.wr_en   = c_wr_p;
                o_req.wr_addr = r_paddr;
            end
            tcst_pkg::S_WRITE_U: begin
                o_req.wr_en   = r_wr_u;
                o_req.wr_addr = c_uidx;
                o_req.wr_data = r_nu;
            end
            tcst_pkg::S_OUT_FIRST: begin
                o_res.valid = 1'b1;
                c_item      = r_first;
            end
            tcst_pkg::S_OUT_LAST: begin
                o_res.valid = 1'b1;
                o_res.last  = 1'b1;
            end
            default: begin
                i_cmd.ready = 1'b0;
            end
        endcase
        o_res.target         = c_item.target;
        o_res.kind           = c_item.kind;
        o_res.line_state_out = c_item.ls;
        o_res.shown_number   = c_item.shown;
        o_res.failed         = r_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcst_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tcst_pkg::S_IDLE && i_cmd.valid) begin
            r_cmd    <= i_cmd.cmd;
            r_unit   <= i_cmd.unit;
            r_dialed <= i_cmd.dialed;
        end
        if (r_state == tcst_pkg::S_PEER) begin
            r_eu    <= i_rd;
            r_paddr <= o_req.rd_addr;
        end
        if (r_state == tcst_pkg::S_EXEC) begin
            r_nu    <= c_nu;
            r_wr_u  <= c_wr_u;
            r_first <= c_first;
            r_last  <= c_last;
            r_two   <= c_two;
            r_fail  <= c_fail;
        end
    end

endmodule

[sv/telephone_call_state_table.sv]
// Call state table for a small exchange: one entry per extension with call-rule updates.
// Top level; instantiates tcst_ctrl and tcst_table, uses tcst_pkg and the channel interfaces.
//
// Commands arrive on i_cmd (cmd, unit, dialed) as valid/ready transactions. Each command
// yields one or two result transactions on o_res; every result of a command carries the
// same failed flag and the final one carries last. When two results are produced, the
// notice for the peer line (or the chat forward marker) comes first.
// The block handles one command at a time and holds i_cmd.ready low until the final
// result has been taken. The table is read for the caller when the command is accepted,
// then read for the peer in S_PEER, written for the peer in S_EXEC and written for the
// caller in S_WRITE_U; the results are then offered in S_OUT_FIRST (two results only)
// and S_OUT_LAST.
// A stalled receiver simply holds the current result; the block waits with no loss.
// Synchronous reset clears the registered, peer-link and state-valid flags of all entries
// at once, so the block accepts a command in the first cycle after reset.
module telephone_call_state_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcst_cmd_if.sink    i_cmd,
    tcst_res_if.source  o_res
);

    tcst_pkg::t_tbl_req w_req;
    tcst_pkg::t_entry   w_rd;

    tcst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .o_req   (w_req),
        .i_rd    (w_rd)
    );

    tcst_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rd    (w_rd)
    );

endmodule

[sv/tcst_checker.sv]
// Port-level checker for the call state table, bound to the top level.
// Depends on tcst_pkg for the result kind codes.
module tcst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cmd_valid,
    input logic       i_cmd_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_res_kind,
    input logic       i_res_last
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && i_cmd_ready) |=> !i_cmd_ready)
        else $error("Command accepted while a previous transaction was in progress.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_cmd_ready)
        else $error("Result offered while commands are being taken.");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && !i_res_last) |=> i_res_valid)
        else $error("Result sequence ended without a final transaction.");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && i_res_last) |=> (!i_res_valid && i_cmd_ready))
        else $error("Block did not return to idle after the final result.");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_kind == tcst_pkg::KIND_STATUS) |-> i_res_last)
        else $error("Status-only result without last set.");

endmodule

bind telephone_call_state_table tcst_checker u_tcst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_valid  (i_cmd.valid),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.kind),
    .i_res_last   (o_res.last)
);

[tb/telephone_call_state_table_tb.sv]
// Self-checking testbench for the telephone call state table: directed call scenarios, then
// random call traffic with idle gaps on both channels, checked against a scoreboard predictor.
// Depends on tcst_pkg, the tcst channel interfaces and the telephone_call_state_table top.
module telephone_call_state_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcst_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RANDOM_CALLS = 750;

    typedef struct packed {
        logic [UNIT_W-1:0] target;
        t_kind             kind;
        t_line_state       ls;
        logic [UNIT_W-1:0] shown;
        logic              failed;
        logic              last;
    } notice_t;

    class call_board;
        logic        registered [MAX_LINES];
        t_line_state line       [MAX_LINES];
        logic        linked     [MAX_LINES];
        t_idx        peer       [MAX_LINES];
        notice_t     awaited    [$];
        int          errors;

        function new();
            for (int i = 0; i < MAX_LINES; i++) begin
                registered[i] = 1'b0;
                line[i]       = LS_ON_HOOK;
                linked[i]     = 1'b0;
                peer[i]       = '0;
            end
            errors = 0;
        endfunction

        function notice_t marker(logic [UNIT_W-1:0] tgt, t_kind k);
            notice_t r;
            r.target = tgt;
            r.kind   = k;
            r.ls     = LS_ON_HOOK;
            r.shown  = '0;
            r.failed = 1'b0;
            r.last   = 1'b0;
            return r;
        endfunction

        function notice_t state_notice(t_idx x);
            notice_t r;
            r    = marker(UNIT_W'(x), KIND_NOTICE);
            r.ls = line[x];
            if (line[x] == LS_ON_HOOK) begin
                r.shown = UNIT_W'(x);
            end else if (line[x] == LS_CONNECTED && linked[x]) begin
                r.shown = UNIT_W'(peer[x]);
            end
            return r;
        endfunction

        function void log_command(logic [2:0] c, logic [UNIT_W-1:0] u, logic [DIAL_W-1:0] d);
            notice_t     batch [$];
            t_line_state s;
            t_idx        p;
            t_idx        dd;
            logic        refused;
            refused = 1'b0;
            dd      = t_idx'(d);
            if (c > CMD_CHAT || 32'(u) >= MAX_LINES || (c != CMD_REGISTER && !registered[u])) begin
                refused = 1'b1;
            end else begin
                s = line[u];
                case (c)
                    CMD_REGISTER: begin
                        if (registered[u]) begin
                            refused = 1'b1;
                        end else begin
                            registered[u] = 1'b1;
                            line[u]       = LS_ON_HOOK;
                            linked[u]     = 1'b0;
                            batch.push_back(state_notice(u));
                        end
                    end
                    CMD_UNREGISTER: begin
                        if (linked[u]) begin
                            p = peer[u];
                            if (line[p] == LS_RING_BACK || line[p] == LS_CONNECTED) begin
                                line[p] = LS_DIAL_TONE;
                            end else if (line[p] == LS_RINGING) begin
                                line[p] = LS_ON_HOOK;
                            end
                            linked[p] = 1'b0;
                            batch.push_back(state_notice(p));
                        end
                        registered[u] = 1'b0;
                        line[u]       = LS_ON_HOOK;
                        linked[u]     = 1'b0;
                    end
                    CMD_PICKUP: begin
                        if (s == LS_ON_HOOK) begin
                            line[u] = LS_DIAL_TONE;
                        end else if (s == LS_RINGING && linked[u]) begin
                            p       = peer[u];
                            line[u] = LS_CONNECTED;
                            line[p] = LS_CONNECTED;
                            batch.push_back(state_notice(p));
                        end
                        batch.push_back(state_notice(u));
                    end
                    CMD_HANGUP: begin
                        if ((s == LS_CONNECTED || s == LS_RING_BACK || s == LS_RINGING)
                                && linked[u]) begin
                            p         = peer[u];
                            line[p]   = (s == LS_RING_BACK) ? LS_ON_HOOK : LS_DIAL_TONE;
                            linked[p] = 1'b0;
                            batch.push_back(state_notice(p));
                        end
                        line[u]   = LS_ON_HOOK;
                        linked[u] = 1'b0;
                        batch.push_back(state_notice(u));
                    end
                    CMD_DIAL: begin
                        if (s == LS_DIAL_TONE) begin
                            if (32'(d) >= MAX_LINES || !registered[dd]) begin
                                line[u] = LS_ERROR;
                            end else if (line[dd] == LS_ON_HOOK) begin
                                linked[u] = 1'b1;
                                peer[u]   = dd;
                                linked[dd] = 1'b1;
                                peer[dd]  = u;
                                line[u]   = LS_RING_BACK;
                                line[dd]  = LS_RINGING;
                                batch.push_back(state_notice(dd));
                            end else begin
                                line[u] = LS_BUSY;
                            end
                        end
                        batch.push_back(state_notice(u));
                    end
                    default: begin
                        if (s == LS_CONNECTED && linked[u]) begin
                            batch.push_back(marker(UNIT_W'(peer[u]), KIND_FORWARD));
                        end else begin
                            refused = 1'b1;
                        end
                        batch.push_back(state_notice(u));
                    end
                endcase
            end
            if (batch.size() == 0) begin
                batch.push_back(marker(u, KIND_STATUS));
            end
            foreach (batch[k]) begin
                batch[k].failed = refused;
                batch[k].last   = (k == batch.size() - 1);
                awaited.push_back(batch[k]);
            end
        endfunction

        function void flag(string why, notice_t want, notice_t got);
            errors++;
            if (errors <= 10) begin
                $display("Mismatch (%s): expected target=%0d kind=%0d state=%0d shown=%0d",
                         why, want.target, want.kind, want.ls, want.shown,
                         " failed=%0d last=%0d; got target=%0d kind=%0d state=%0d shown=%0d",
                         want.failed, want.last, got.target, got.kind, got.ls, got.shown,
                         " failed=%0d last=%0d", got.failed, got.last);
            end
        endfunction

        function void check_result(notice_t got);
            notice_t want;
            if (awaited.size() == 0) begin
                flag("unexpected result", marker('0, KIND_NOTICE), got);
            end else begin
                want = awaited.pop_front();
                if (got.target !== want.target || got.kind !== want.kind
                        || got.ls !== want.ls || got.shown !== want.shown
                        || got.failed !== want.failed || got.last !== want.last) begin
                    flag("field", want, got);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   cycles;
    logic [UNIT_W-1:0] pool [8];

    call_board board = new();

    tcst_cmd_if cmd_bus();
    tcst_res_if res_bus();

    telephone_call_state_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_bus.ready <= quiet || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge i_clk) begin
        notice_t got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.target = res_bus.target;
            got.kind   = t_kind'(res_bus.kind);
            got.ls     = t_line_state'(res_bus.line_state_out);
            got.shown  = res_bus.shown_number;
            got.failed = res_bus.failed;
            got.last   = res_bus.last;
            board.check_result(got);
        end
    end

    task automatic send_cmd(input logic [2:0] c, input logic [UNIT_W-1:0] u,
                            input logic [DIAL_W-1:0] d);
        while (!quiet && $urandom_range(99) < 26) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid  <= 1'b1;
        cmd_bus.cmd    <= c;
        cmd_bus.unit   <= u;
        cmd_bus.dialed <= d;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        board.log_command(c, u, d);
    endtask

    task automatic pick_call(output logic [2:0] c, output logic [UNIT_W-1:0] u,
                             output logic [DIAL_W-1:0] d);
        int roll;
        roll = $urandom_range(99);
        u    = pool[$urandom_range(7)];
        d    = DIAL_W'(pool[$urandom_range(7)]);
        if (roll > 92) begin
            d = DIAL_W'($urandom_range(255));
        end
        if (roll < 12) begin
            c = 3'($urandom_range(7));
            u = UNIT_W'($urandom_range(63));
            d = DIAL_W'($urandom_range(255));
        end else if (!board.registered[u]) begin
            c = (roll < 90) ? CMD_REGISTER : 3'($urandom_range(7));
        end else begin
            case (board.line[u])
                LS_ON_HOOK:   c = (roll < 70) ? CMD_PICKUP : (roll < 80) ? CMD_UNREGISTER :
                                  (roll < 90) ? CMD_DIAL : CMD_HANGUP;
                LS_DIAL_TONE: c = (roll < 75) ? CMD_DIAL : (roll < 90) ? CMD_HANGUP : CMD_CHAT;
                LS_RINGING:   c = (roll < 70) ? CMD_PICKUP : (roll < 90) ? CMD_HANGUP :
                                  CMD_UNREGISTER;
                LS_RING_BACK: c = (roll < 37) ? CMD_HANGUP : (roll < 62) ? CMD_CHAT :
                                  (roll < 72) ? CMD_UNREGISTER : CMD_PICKUP;
                LS_CONNECTED: c = (roll < 50) ? CMD_CHAT : (roll < 80) ? CMD_HANGUP :
                                  (roll < 90) ? CMD_UNREGISTER : CMD_PICKUP;
                default:      c = (roll < 75) ? CMD_HANGUP : (roll < 85) ? CMD_DIAL : CMD_CHAT;
            endcase
        end
    endtask

    initial begin
        logic [2:0]        c;
        logic [UNIT_W-1:0] u;
        logic [DIAL_W-1:0] d;
        quiet          = 1'b0;
        i_rst_n        <= 1'b0;
        cmd_bus.valid  <= 1'b0;
        cmd_bus.cmd    <= CMD_REGISTER;
        cmd_bus.unit   <= '0;
        cmd_bus.dialed <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(CMD_REGISTER,   6'd0,  8'd0);
        send_cmd(CMD_REGISTER,   6'd63, 8'd255);
        send_cmd(CMD_REGISTER,   6'd5,  8'd0);
        send_cmd(CMD_REGISTER,   6'd0,  8'd0);
        send_cmd(CMD_UNREGISTER, 6'd10, 8'd0);
        send_cmd(CMD_PICKUP,     6'd7,  8'd0);
        send_cmd(CMD_SPARE_A,    6'd0,  8'd0);
        send_cmd(CMD_SPARE_B,    6'd63, 8'd255);
        send_cmd(CMD_PICKUP,     6'd0,  8'd0);
        send_cmd(CMD_DIAL,       6'd0,  8'd200);
        send_cmd(CMD_HANGUP,     6'd0,  8'd0);
        send_cmd(CMD_PICKUP,     6'd0,  8'd0);
        send_cmd(CMD_DIAL,       6'd0,  8'd0);
        send_cmd(CMD_HANGUP,     6'd0,  8'd0);
        send_cmd(CMD_PICKUP,     6'd0,  8'd0);
        send_cmd(CMD_DIAL,       6'd0,  8'd63);
        send_cmd(CMD_CHAT,       6'd0,  8'd0);
        send_cmd(CMD_PICKUP,     6'd63, 8'd0);
        send_cmd(CMD_CHAT,       6'd0,  8'd0);
        send_cmd(CMD_PICKUP,     6'd5,  8'd0);
        send_cmd(CMD_DIAL,       6'd5,  8'd0);
        send_cmd(CMD_UNREGISTER, 6'd63, 8'd0);
        send_cmd(CMD_HANGUP,     6'd5,  8'd0);
        send_cmd(CMD_DIAL,       6'd0,  8'd5);
        send_cmd(CMD_UNREGISTER, 6'd5,  8'd0);

        for (int i = 0; i < RANDOM_CALLS; i++) begin
            if (i % 125 == 0) begin
                foreach (pool[k]) pool[k] = UNIT_W'($urandom_range(63));
            end
            quiet = (i >= 300 && i < 450);
            pick_call(c, u, d);
            send_cmd(c, u, d);
        end
        quiet = 1'b0;
        cmd_bus.valid <= 1'b0;

        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/tcst_pkg.sv
sv/tcst_if.sv
sv/tcst_table.sv
sv/tcst_ctrl.sv
sv/telephone_call_state_table.sv
sv/tcst_checker.sv
tb/telephone_call_state_table_tb.sv
